FILE: hdl/srtf_pkg.sv
// Shared types, constants and codes for the SRTF scheduler.
// Used by the controller, the datapath and the top level; depends on nothing.
`timescale 1ns / 1ps

package srtf_pkg;

  // Table size and derived index widths.
  localparam int MAX_PROCESSES = 16;
  localparam int IDX_W         = $clog2(MAX_PROCESSES);
  localparam int CNT_W         = $clog2(MAX_PROCESSES + 1);

  // Field widths of a request and a result.
  localparam int TIME_W  = 24;
  localparam int BURST_W = 16;
  localparam int PNUM_W  = 5;
  localparam int PCALC_W = (CNT_W > PNUM_W) ? CNT_W : PNUM_W;

  // One table entry as held in the process RAM: arrival, burst, remaining.
  localparam int WORD_W = TIME_W + BURST_W + BURST_W;

  localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};

  // Request kinds.
  typedef enum logic [1:0] {
    KIND_ADD   = 2'd0,
    KIND_TICK  = 2'd1,
    KIND_CLEAR = 2'd2,
    KIND_NONE  = 2'd3
  } kind_e;

  // Controller states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FINAL,
    ST_COMMIT
  } state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic scan_issue;
    logic commit;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic count_zero;
    logic scan_last;
  } status_t;

endpackage

FILE: hdl/srtf_preemptive_scheduler.sv
// Top level of the preemptive shortest-remaining-time-first scheduler.
// Depends on srtf_pkg, srtf_ctrl and srtf_dp (which holds srtf_ram).
`timescale 1ns / 1ps

// A request is taken when start_i is high and busy_o is low. Add, clear and
// unused kinds go from acceptance straight to the commit state. A tick reads
// the process table one entry per cycle through the single read port of the
// table RAM for N stored processes, compares the last entry read, and then
// commits; on an empty table it commits at once. Every request yields
// exactly one result, shown for one cycle with valid_o high; the receiver
// cannot stall it, so it must take the result in that cycle. busy_o falls in
// the cycle the result is shown, and a new request may be given then.

module srtf_preemptive_scheduler (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start_i,
  output logic                                busy_o,
  input  logic [1:0]                          kind_i,
  input  logic [srtf_pkg::TIME_W-1:0]         arrival_time_i,
  input  logic [srtf_pkg::BURST_W-1:0]        burst_time_i,
  output logic                                valid_o,
  output logic [srtf_pkg::PNUM_W-1:0]         process_number_o,
  output logic                                accepted_o,
  output logic                                finished_o,
  output logic [srtf_pkg::TIME_W-1:0]         current_time_o,
  output logic [srtf_pkg::TIME_W-1:0]         turnaround_time_o,
  output logic [srtf_pkg::TIME_W-1:0]         waiting_time_o
);

  srtf_pkg::cmd_t    cmd;
  srtf_pkg::status_t status;

  // Sequencing of each request.
  srtf_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start_i),
    .kind_i   (kind_i),
    .status_i (status),
    .cmd_o    (cmd),
    .busy_o   (busy_o)
  );

  // Table, time and result computation.
  srtf_dp u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .status_o          (status),
    .kind_i            (kind_i),
    .arrival_time_i    (arrival_time_i),
    .burst_time_i      (burst_time_i),
    .valid_o           (valid_o),
    .process_number_o  (process_number_o),
    .accepted_o        (accepted_o),
    .finished_o        (finished_o),
    .current_time_o    (current_time_o),
    .turnaround_time_o (turnaround_time_o),
    .waiting_time_o    (waiting_time_o)
  );

  // An accepted request always makes the block busy.
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o |=> busy_o)
    else $error("busy_o did not rise after an accepted request");

  // A result only follows a cycle in which the block was busy.
  a_result_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> $past(busy_o))
    else $error("result strobe without a preceding busy cycle");

  // A finished process carries a real number and an accepted flag.
  a_finish_numbered: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && finished_o |-> (process_number_o != '0) && accepted_o)
    else $error("finished result without a process number");

  // A rejected add reports no process number.
  a_reject_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && !accepted_o |-> (process_number_o == '0) && !finished_o)
    else $error("rejected request carries a process number");

endmodule

FILE: hdl/srtf_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// Stands alone; holds the process table of the scheduler.
`timescale 1ns / 1ps

module srtf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port and registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: hdl/srtf_ctrl.sv
// Controller state machine of the SRTF scheduler.
// Depends on srtf_pkg; drives the datapath through cmd_t and reads status_t.
`timescale 1ns / 1ps

module srtf_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [1:0]       kind_i,
  input  srtf_pkg::status_t status_i,
  output srtf_pkg::cmd_t   cmd_o,
  output logic             busy_o
);

  srtf_pkg::state_e state_q, state_d;

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= srtf_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state and commands.
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      srtf_pkg::ST_IDLE: begin
        if (start_i) begin
          cmd_o.load = 1'b1;
          // A tick on a non-empty table scans every stored entry; all else commits at once.
          if (srtf_pkg::kind_e'(kind_i) == srtf_pkg::KIND_TICK && !status_i.count_zero) begin
            state_d = srtf_pkg::ST_SCAN;
          end else begin
            state_d = srtf_pkg::ST_COMMIT;
          end
        end
      end
      srtf_pkg::ST_SCAN: begin
        cmd_o.scan_issue = 1'b1;
        if (status_i.scan_last) begin
          state_d = srtf_pkg::ST_FINAL;
        end
      end
      srtf_pkg::ST_FINAL: begin
        // The last read entry is compared in this cycle.
        state_d = srtf_pkg::ST_COMMIT;
      end
      srtf_pkg::ST_COMMIT: begin
        cmd_o.commit = 1'b1;
        state_d      = srtf_pkg::ST_IDLE;
      end
      default: begin
        state_d = srtf_pkg::ST_IDLE;
      end
    endcase
  end

  assign busy_o = (state_q != srtf_pkg::ST_IDLE);

endmodule

FILE: hdl/srtf_dp.sv
// Datapath of the SRTF scheduler: process table, done flags, time, scan and result.
// Depends on srtf_pkg and srtf_ram; commanded by srtf_ctrl.
`timescale 1ns / 1ps

module srtf_dp (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  srtf_pkg::cmd_t                         cmd_i,
  output srtf_pkg::status_t                      status_o,
  input  logic [1:0]                             kind_i,
  input  logic [srtf_pkg::TIME_W-1:0]            arrival_time_i,
  input  logic [srtf_pkg::BURST_W-1:0]           burst_time_i,
  output logic                                   valid_o,
  output logic [srtf_pkg::PNUM_W-1:0]            process_number_o,
  output logic                                   accepted_o,
  output logic                                   finished_o,
  output logic [srtf_pkg::TIME_W-1:0]            current_time_o,
  output logic [srtf_pkg::TIME_W-1:0]            turnaround_time_o,
  output logic [srtf_pkg::TIME_W-1:0]            waiting_time_o
);

  localparam int TW = srtf_pkg::TIME_W;
  localparam int BW = srtf_pkg::BURST_W;
  localparam int IW = srtf_pkg::IDX_W;
  localparam int CW = srtf_pkg::CNT_W;
  localparam int NP = srtf_pkg::MAX_PROCESSES;

  // Latched request.
  srtf_pkg::kind_e     item_kind_q;
  logic [TW-1:0]       item_arr_q;
  logic [BW-1:0]       item_burst_q;

  // Scheduler state.
  logic [TW-1:0]       time_q, time_d;
  logic [CW-1:0]       count_q, count_d;
  logic [NP-1:0]       done_q, done_d;

  // Scan pipeline and running best candidate.
  logic [IW-1:0]       rd_idx_q;
  logic                cmp_valid_q;
  logic [IW-1:0]       cmp_idx_q;
  logic                found_q;
  logic [IW-1:0]       best_idx_q;
  logic [TW-1:0]       best_arr_q;
  logic [BW-1:0]       best_rem_q;
  logic [BW-1:0]       best_burst_q;

  // Result registers.
  logic                valid_q;
  logic [srtf_pkg::PNUM_W-1:0] pnum_q, pnum_d;
  logic                acc_q, acc_d;
  logic                fin_q, fin_d;
  logic [TW-1:0]       tat_q, tat_d;
  logic [TW-1:0]       wt_q, wt_d;

  // Table RAM.
  logic                       ram_we;
  logic [IW-1:0]              ram_waddr;
  logic [srtf_pkg::WORD_W-1:0] ram_wdata;
  logic [srtf_pkg::WORD_W-1:0] ram_rdata;
  logic [TW-1:0]              rd_arr;
  logic [BW-1:0]              rd_burst;
  logic [BW-1:0]              rd_rem;

  srtf_ram #(
    .WIDTH (srtf_pkg::WORD_W),
    .DEPTH (NP)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (rd_idx_q),
    .rdata_o (ram_rdata)
  );

  assign rd_arr   = ram_rdata[srtf_pkg::WORD_W-1 -: TW];
  assign rd_burst = ram_rdata[2*BW-1 -: BW];
  assign rd_rem   = ram_rdata[BW-1:0];

  // Status to the controller.
  assign status_o.count_zero = (count_q == '0);
  assign status_o.scan_last  = (CW'(rd_idx_q) == count_q - CW'(1));

  // Candidate test for the entry whose read data is present.
  logic cand_ok, cand_better;
  assign cand_ok     = cmp_valid_q && !done_q[cmp_idx_q] && (rd_arr <= time_q);
  assign cand_better = !found_q || (rd_rem < best_rem_q) ||
                       ((rd_rem == best_rem_q) && (rd_arr < best_arr_q));

  // Latch the request on acceptance.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      item_kind_q  <= srtf_pkg::kind_e'(kind_i);
      item_arr_q   <= arrival_time_i;
      item_burst_q <= burst_time_i;
    end
  end

  // Scan address, compare stage and best-candidate registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_idx_q    <= '0;
      cmp_valid_q <= 1'b0;
      cmp_idx_q   <= '0;
      found_q     <= 1'b0;
    end else begin
      cmp_valid_q <= cmd_i.scan_issue;
      cmp_idx_q   <= rd_idx_q;
      if (cmd_i.load) begin
        rd_idx_q <= '0;
        found_q  <= 1'b0;
      end else begin
        if (cmd_i.scan_issue) begin
          rd_idx_q <= rd_idx_q + IW'(1);
        end
        if (cand_ok && cand_better) begin
          found_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cand_ok && cand_better) begin
      best_idx_q   <= cmp_idx_q;
      best_arr_q   <= rd_arr;
      best_rem_q   <= rd_rem;
      best_burst_q <= rd_burst;
    end
  end

  // Commit of one request: table update, time, and result values.
  logic [TW-1:0]           time_inc;
  logic [BW-1:0]           rem_dec;
  logic [TW-1:0]           tat_calc;
  logic [srtf_pkg::PCALC_W-1:0] add_num;
  logic [srtf_pkg::PCALC_W-1:0] run_num;

  assign time_inc = (time_q == srtf_pkg::TIME_MAX) ? time_q : time_q + TW'(1);
  assign rem_dec  = best_rem_q - BW'(1);
  assign tat_calc = time_inc - best_arr_q;
  assign add_num  = srtf_pkg::PCALC_W'(count_q) + srtf_pkg::PCALC_W'(1);
  assign run_num  = srtf_pkg::PCALC_W'(best_idx_q) + srtf_pkg::PCALC_W'(1);

  always_comb begin
    time_d    = time_q;
    count_d   = count_q;
    done_d    = done_q;
    ram_we    = 1'b0;
    ram_waddr = best_idx_q;
    ram_wdata = {best_arr_q, best_burst_q, rem_dec};
    pnum_d    = '0;
    acc_d     = 1'b1;
    fin_d     = 1'b0;
    tat_d     = '0;
    wt_d      = '0;
    if (cmd_i.commit) begin
      case (item_kind_q)
        srtf_pkg::KIND_ADD: begin
          if (count_q == CW'(NP)) begin
            acc_d = 1'b0;
          end else begin
            ram_we    = 1'b1;
            ram_waddr = count_q[IW-1:0];
            ram_wdata = {item_arr_q, item_burst_q, item_burst_q};
            done_d[count_q[IW-1:0]] = (item_burst_q == '0);
            count_d   = count_q + CW'(1);
            pnum_d    = add_num[srtf_pkg::PNUM_W-1:0];
          end
        end
        srtf_pkg::KIND_TICK: begin
          time_d = time_inc;
          if (found_q) begin
            ram_we = 1'b1;
            pnum_d = run_num[srtf_pkg::PNUM_W-1:0];
            // The process finishes when its last time unit has run.
            if (rem_dec == '0) begin
              done_d[best_idx_q] = 1'b1;
              fin_d = 1'b1;
              tat_d = tat_calc;
              wt_d  = (tat_calc >= TW'(best_burst_q)) ? tat_calc - TW'(best_burst_q) : '0;
            end
          end
        end
        srtf_pkg::KIND_CLEAR: begin
          time_d  = '0;
          count_d = '0;
          done_d  = '0;
        end
        default: begin
        end
      endcase
    end
  end

  // Scheduler state registers and result strobe.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      time_q  <= '0;
      count_q <= '0;
      done_q  <= '0;
      valid_q <= 1'b0;
    end else begin
      time_q  <= time_d;
      count_q <= count_d;
      done_q  <= done_d;
      valid_q <= cmd_i.commit;
    end
  end

  // Result payload, captured at commit.
  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      pnum_q <= pnum_d;
      acc_q  <= acc_d;
      fin_q  <= fin_d;
      tat_q  <= tat_d;
      wt_q   <= wt_d;
    end
  end

  assign valid_o           = valid_q;
  assign process_number_o  = pnum_q;
  assign accepted_o        = acc_q;
  assign finished_o        = fin_q;
  assign current_time_o    = time_q;
  assign turnaround_time_o = tat_q;
  assign waiting_time_o    = wt_q;

endmodule
